@@ hw/rtl/ksd_pkg.sv @@
// Package for the keystream decryptor and file splitter.
// Holds the transaction payload types, status codes and the key byte table.
// Depends on nothing.
package ksd_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;
    localparam logic [7:0]  SeedBiasLow = 8'h7D;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SIZE = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [11:0] table_index;
        logic [31:0] file_size;
        logic        lump_start;
        logic [31:0] lump_size;
        logic [7:0]  cipher_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  plain_byte;
        logic [11:0] file_number;
        logic        end_of_file;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic        is_data;
        logic [11:0] table_index;
        logic [31:0] file_size;
        logic        lump_start;
        logic [7:0]  plain;
        logic        off_zero;
        logic        next_zero;
    } t_cmd;

    typedef logic [7:0] t_key_table [256];

    function automatic t_key_table build_key_table();
        t_key_table tbl;
        logic [7:0] s;
        for (int i = 0; i < 256; i++) begin
            s = 8'(i);
            tbl[i] = s * (s * s * 8'h73 - 8'h1B) + 8'h0D;
        end
        return tbl;
    endfunction

    localparam t_key_table KeyTable = build_key_table();

endpackage

@@ hw/rtl/keystream_decrypt_file_splitter_top.sv @@
// A data byte is held in the command queue, then in the output register; when
// it opens a new file, the size table read in S_LOOK comes between the two.
// Throughput: one transaction per cycle unless the output stalls; each file start
// waits for the registered read port of the size table RAM.
// Reset clears all control state and the file count; the size table contents
// stay undefined until written.
module keystream_decrypt_file_splitter_top #(
    parameter int unsigned MAX_FILES   = 4096,
    parameter int unsigned ALIGN_BYTES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [12:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ksd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ksd_pkg::t_out_item o_out_data
);
    import ksd_pkg::*;

    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_pop;
    logic w_head_valid;
    t_cmd w_head;

    ksd_front #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    ksd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_data  (w_push_cmd),
        .o_full       (w_q_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    ksd_back #(
        .MAX_FILES (MAX_FILES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

`ifndef ASSERT_OFF
    a_full_has_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_head_valid)
        else $error("queue full without a head entry");

    a_pop_has_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("queue popped while empty");

    a_zero_size_form : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STATUS_ZERO_SIZE)
            |-> (o_out_data.end_of_file && o_out_data.plain_byte == 8'd0))
        else $error("zero-size result malformed");

    a_exhausted_form : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STATUS_EXHAUSTED)
            |-> (!o_out_data.end_of_file && o_out_data.file_number == 12'd0))
        else $error("exhausted result malformed");
`endif

endmodule

@@ hw/rtl/ksd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ksd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/ksd_queue.sv @@
// Short command queue between the front and the back part.
// Depends on ksd_pkg.
module ksd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ksd_pkg::t_cmd i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output ksd_pkg::t_cmd o_head
);
    import ksd_pkg::*;

    t_cmd                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QueuePtrW:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_full       = (r_count == (QueuePtrW + 1)'(QueueDepth));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

endmodule

@@ hw/rtl/ksd_front.sv @@
// Front part: accepts transactions, runs the keystream and the lump offset.
// Depends on ksd_pkg.
module ksd_front #(
    parameter int unsigned ALIGN_BYTES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ksd_pkg::t_in_item i_in_data,
    input  logic             i_q_full,
    output logic             o_push,
    output ksd_pkg::t_cmd    o_cmd
);
    import ksd_pkg::*;

    localparam int unsigned OW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam logic [OW-1:0] OffsetLast = OW'(ALIGN_BYTES - 1);

    logic [7:0]    r_seed, n_seed;
    logic [OW-1:0] r_offset, n_offset;
    logic [7:0]    w_seed_use;
    logic [OW-1:0] w_offset_use;
    logic [OW-1:0] w_offset_next;
    logic          w_accept;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept;

    assign w_seed_use    = i_in_data.lump_start ? (i_in_data.lump_size[7:0] + SeedBiasLow)
                                                : r_seed;
    assign w_offset_use  = i_in_data.lump_start ? '0 : r_offset;
    assign w_offset_next = (w_offset_use == OffsetLast) ? '0 : (w_offset_use + 1'b1);

    always_comb begin
        o_cmd.is_data     = i_in_data.mode;
        o_cmd.table_index = i_in_data.table_index;
        o_cmd.file_size   = i_in_data.file_size;
        o_cmd.lump_start  = i_in_data.lump_start;
        o_cmd.plain       = i_in_data.cipher_byte ^ KeyTable[w_seed_use];
        o_cmd.off_zero    = (w_offset_use == '0);
        o_cmd.next_zero   = (w_offset_next == '0);
    end

    always_comb begin
        n_seed   = r_seed;
        n_offset = r_offset;
        if (w_accept && i_in_data.mode) begin
            n_seed   = w_seed_use + 8'd1;
            n_offset = w_offset_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_offset <= '0;
        end else begin
            r_seed   <= n_seed;
            r_offset <= n_offset;
        end
    end

endmodule

@@ hw/rtl/ksd_back.sv @@
// Back part: size table, file assignment, padding and the output register.
// Depends on ksd_pkg and ksd_ram.
module ksd_back #(
    parameter int unsigned MAX_FILES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [12:0]        i_cfg_wr_data,
    input  logic               i_head_valid,
    input  ksd_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ksd_pkg::t_out_item o_out_data
);
    import ksd_pkg::*;

    localparam int unsigned AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_LOOK = 2'b10
    } t_back_state;

    t_back_state r_state, n_state;
    logic [12:0] r_file_count;
    logic        r_pad, n_pad;
    logic        r_active, n_active;
    logic [31:0] r_rem, n_rem;
    logic [12:0] r_cur, n_cur;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic          w_out_free;
    logic [31:0]   w_usable;
    logic [12:0]   w_next;
    logic          w_exhausted;
    logic          w_drop;
    logic [31:0]   w_idx_ext;
    logic [31:0]   w_next_ext;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [31:0]   w_rd_data;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_usable    = ({19'b0, r_file_count} > 32'(MAX_FILES)) ? 32'(MAX_FILES)
                                                                  : {19'b0, r_file_count};
    assign w_next      = r_cur + 13'd1;
    assign w_exhausted = ({19'b0, w_next} >= w_usable);
    assign w_drop      = r_pad && !i_head.lump_start && !i_head.off_zero;
    assign w_idx_ext   = 32'(i_head.table_index);
    assign w_next_ext  = 32'(w_next);

    ksd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_FILES)
    ) u_size_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_idx_ext[AW-1:0]),
        .i_wr_data (i_head.file_size),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_next_ext[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_pad       = r_pad;
        n_active    = r_active;
        n_rem       = r_rem;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        case (r_state)
            S_RUN: begin
                if (i_head_valid) begin
                    if (!i_head.is_data) begin
                        w_wr_en = (w_idx_ext < 32'(MAX_FILES));
                        o_pop   = 1'b1;
                    end else if (w_drop) begin
                        o_pop = 1'b1;
                    end else if (w_out_free) begin
                        n_pad = 1'b0;
                        if (r_active) begin
                            n_rem                   = r_rem - 32'd1;
                            n_out_valid             = 1'b1;
                            n_out.plain_byte        = i_head.plain;
                            n_out.file_number       = r_cur[11:0];
                            n_out.end_of_file       = (r_rem == 32'd1);
                            n_out.status            = STATUS_OK;
                            o_pop                   = 1'b1;
                            if (r_rem == 32'd1) begin
                                n_active = 1'b0;
                                n_pad    = !i_head.next_zero;
                            end
                        end else if (w_exhausted) begin
                            n_out_valid       = 1'b1;
                            n_out.plain_byte  = i_head.plain;
                            n_out.file_number = '0;
                            n_out.end_of_file = 1'b0;
                            n_out.status      = STATUS_EXHAUSTED;
                            o_pop             = 1'b1;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_LOOK;
                        end
                    end
                end
            end
            S_LOOK: begin
                if (w_out_free) begin
                    n_cur             = w_next;
                    o_pop             = 1'b1;
                    n_state           = S_RUN;
                    n_out_valid       = 1'b1;
                    n_out.file_number = w_next[11:0];
                    if (w_rd_data == 32'd0) begin
                        n_out.plain_byte  = 8'd0;
                        n_out.end_of_file = 1'b1;
                        n_out.status      = STATUS_ZERO_SIZE;
                        n_pad             = !i_head.next_zero;
                    end else begin
                        n_rem             = w_rd_data - 32'd1;
                        n_out.plain_byte  = i_head.plain;
                        n_out.end_of_file = (w_rd_data == 32'd1);
                        n_out.status      = STATUS_OK;
                        if (w_rd_data == 32'd1) begin
                            n_pad = !i_head.next_zero;
                        end else begin
                            n_active = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_file_count <= '0;
            r_pad        <= 1'b0;
            r_active     <= 1'b0;
            r_rem        <= '0;
            r_cur        <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pad       <= n_pad;
            r_active    <= n_active;
            r_rem       <= n_rem;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_file_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
